### hw/rtl/robust_moving_average_outlier_reject_unit_macros.svh
// ----------------------------------------------------------------------------
// robust moving average outlier reject unit - assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ROBUST_MOVING_AVERAGE_OUTLIER_REJECT_UNIT_MACROS_SVH
`define ROBUST_MOVING_AVERAGE_OUTLIER_REJECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle as the antecedent
`define RMAOR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmaor assertion failed");

// consequent holds in the cycle after the antecedent
`define RMAOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmaor assertion failed");

`else

`define RMAOR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RMAOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/rmaor_pkg.sv
// ----------------------------------------------------------------------------
// rmaor_pkg
// shared types of the robust moving average outlier reject unit
// ----------------------------------------------------------------------------
`default_nettype none

package rmaor_pkg;

    // controls from the sequencer to the window store
    typedef struct packed {
        logic load;      // new sample into the newest slot, keep weight 1
        logic rot_sk;    // rotate sample and keep rings by one
        logic set_res;   // new residual into the newest slot
        logic rot_res;   // rotate residual ring by one
        logic set_keep;  // final keep weight into the newest slot
        logic keep;      // value for set_keep
        logic shift;     // retire oldest entry, newest becomes history
    } t_win_ctrl;

endpackage

`default_nettype wire

### hw/rtl/rmaor_div.sv
// ----------------------------------------------------------------------------
// rmaor_div
// bit-serial divider, signed dividend and unsigned divisor, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module rmaor_div #(
    parameter int NW = 26,
    parameter int DW = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [NW-1:0]      o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [NW-1:0] r_quo;

    logic [DW:0]   v_try;
    logic [DW:0]   v_diff;
    logic          v_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_q;
    logic [NW-1:0] n_quo;
    logic [NW-1:0] v_mag;

    always_comb begin
        v_try  = {r_rem, r_q[NW-1]};
        v_ge   = v_try >= {1'b0, r_div};
        v_diff = v_try - {1'b0, r_div};
        n_rem  = v_ge ? v_diff[DW-1:0] : v_try[DW-1:0];
        n_q    = {r_q[NW-2:0], v_ge};
        n_quo  = r_neg ? (~n_q + NW'(1)) : n_q;
        v_mag  = i_dividend[NW-1] ? (~i_dividend + NW'(1)) : i_dividend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_neg  <= i_dividend[NW-1];
                r_q    <= v_mag;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= n_quo;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### hw/rtl/rmaor_window.sv
// ----------------------------------------------------------------------------
// rmaor_window
// sample, residual and keep rings; slot WINDOW-1 holds the item in progress
// ----------------------------------------------------------------------------
`default_nettype none

module rmaor_window #(
    parameter int WINDOW       = 3,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire rmaor_pkg::t_win_ctrl                    i_ctrl,
    input  wire logic [SAMPLE_WIDTH-1:0]                 i_sample,
    input  wire logic [SAMPLE_WIDTH:0]                   i_res,
    output logic [SAMPLE_WIDTH-1:0]                      o_head_smp,
    output logic                                         o_head_keep,
    output logic [WINDOW-1:0][SAMPLE_WIDTH:0]            o_res
);

    localparam int HIST = WINDOW - 1;

    logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] r_smp;
    logic [WINDOW-1:0][SAMPLE_WIDTH:0]   r_res;
    logic [WINDOW-1:0]                   r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp  <= '0;
            r_res  <= '0;
            r_keep <= '1;
        end else begin
            if (i_ctrl.load) begin
                r_smp[HIST]  <= i_sample;
                r_keep[HIST] <= 1'b1;
            end
            if (i_ctrl.rot_sk) begin
                for (int i = 0; i < WINDOW; i++) begin
                    r_smp[i]  <= r_smp[(i + 1) % WINDOW];
                    r_keep[i] <= r_keep[(i + 1) % WINDOW];
                end
            end
            if (i_ctrl.set_res) begin
                r_res[HIST] <= i_res;
            end
            if (i_ctrl.rot_res) begin
                for (int i = 0; i < WINDOW; i++) begin
                    r_res[i] <= r_res[(i + 1) % WINDOW];
                end
            end
            if (i_ctrl.set_keep) begin
                r_keep[HIST] <= i_ctrl.keep;
            end
            // oldest drops out, newest slot becomes the last history entry
            if (i_ctrl.shift) begin
                for (int i = 0; i < HIST; i++) begin
                    r_smp[i]  <= r_smp[i + 1];
                    r_res[i]  <= r_res[i + 1];
                    r_keep[i] <= r_keep[i + 1];
                end
            end
        end
    end

    assign o_head_smp  = r_smp[0];
    assign o_head_keep = r_keep[0];
    assign o_res       = r_res;

endmodule

`default_nettype wire

### hw/rtl/robust_moving_average_outlier_reject_unit.sv
// ----------------------------------------------------------------------------
// robust_moving_average_outlier_reject_unit
// moving average of kept samples with median residual outlier rejection
//
//   channel   direction  handshake                          payload
//   sample    in         i_sample_valid / o_sample_ready    i_sample
//   smoothed  out        o_smoothed_valid / i_smoothed_ready o_smoothed
//   config    in         apb psel/penable/pwrite/pready     paddr, pwdata, prdata
//
// each item passes through the window sum, a division for the average, the
// residual, the median scan, the trust product and compare and a second division,
// one quotient bit per cycle in the bit-serial divider; window sum and median scan
// each visit all WINDOW entries; a new item is taken only once back in idle
// synchronous active-low reset; window returns to zero samples and residuals
// with all keep weights set, trust factor returns to 6
// a new item is taken while the last result still waits at the output register;
// a finished item waits in place until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

`include "robust_moving_average_outlier_reject_unit_macros.svh"

module robust_moving_average_outlier_reject_unit #(
    parameter int WINDOW       = 3,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire logic                    i_sample_valid,
    output logic                         o_sample_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                         o_smoothed_valid,
    input  wire logic                    i_smoothed_ready,
    output logic [SAMPLE_WIDTH-1:0]      o_smoothed
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int RESW  = SW + 1;
    localparam int SUMW  = SW + $clog2(WINDOW);
    localparam int CNTW  = $clog2(WINDOW + 1);
    localparam int STEPW = $clog2(WINDOW);
    localparam int RHSW  = SW + 6;
    localparam int M_LO  = (WINDOW - 1) / 2;
    localparam int M_HI  = WINDOW / 2;

    localparam logic       REG_TRUST   = 1'b0;
    localparam logic [3:0] TRUST_RESET = 4'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_DG1,
        S_DW1,
        S_RES,
        S_MED,
        S_MUL,
        S_CMP,
        S_DG2,
        S_DW2,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [3:0]       r_trust;
    logic [STEPW-1:0] r_step;
    logic [SUMW-1:0]  r_acc;
    logic [CNTW-1:0]  r_cnt;
    logic [SW-1:0]    r_x;
    logic [RESW-1:0]  r_res;
    logic [RESW-1:0]  r_med_lo;
    logic [RESW-1:0]  r_med_hi;
    logic [RHSW-1:0]  r_rhs;
    logic             r_out_valid;
    logic [SW-1:0]    r_smoothed;

    rmaor_pkg::t_win_ctrl            w_ctrl;
    logic [SW-1:0]                   w_head_smp;
    logic                            w_head_keep;
    logic [WINDOW-1:0][RESW-1:0]     w_res;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [SUMW-1:0]                 w_quo;
    logic [CNTW-1:0]                 w_divisor;

    logic              w_accept;
    logic              w_out_fire;
    logic              w_cfg_wr;
    logic              v_last;
    logic [SW-1:0]     v_avg;
    logic [RESW-1:0]   v_diff;
    logic [RESW-1:0]   v_abs;
    logic [WINDOW-1:0] v_lt;
    logic [WINDOW-1:0] v_le;
    logic [CNTW-1:0]   v_lt_cnt;
    logic [CNTW-1:0]   v_le_cnt;
    logic              v_is_lo;
    logic              v_is_hi;
    logic [RESW:0]     v_msum;
    logic              v_keep;
    logic [SUMW-1:0]   v_head_ext;
    logic [SUMW-1:0]   v_x_ext;
    logic              v_div_wait;

    assign pready           = 1'b1;
    assign w_cfg_wr         = psel && penable && pwrite && pready;
    assign prdata           = (paddr[2] == REG_TRUST) ? {28'd0, r_trust} : 32'd0;
    assign o_sample_ready   = (r_state == S_IDLE);
    assign w_accept         = i_sample_valid && o_sample_ready;
    assign w_out_fire       = (r_state == S_OUT) && (!r_out_valid || i_smoothed_ready);
    assign o_smoothed_valid = r_out_valid;
    assign o_smoothed       = r_smoothed;

    always_comb begin
        v_last     = (r_step == STEPW'(WINDOW - 1));
        v_avg      = w_quo[SW-1:0];
        v_diff     = {r_x[SW-1], r_x} - {v_avg[SW-1], v_avg};
        v_abs      = v_diff[RESW-1] ? (~v_diff + RESW'(1)) : v_diff;
        v_head_ext = {{(SUMW - SW){w_head_smp[SW-1]}}, w_head_smp};
        v_x_ext    = {{(SUMW - SW){r_x[SW-1]}}, r_x};
        // rank of the candidate at the ring head among all residuals
        for (int j = 0; j < WINDOW; j++) begin
            v_lt[j] = w_res[j] < w_res[0];
            v_le[j] = w_res[j] <= w_res[0];
        end
        v_lt_cnt  = CNTW'($countones(v_lt));
        v_le_cnt  = CNTW'($countones(v_le));
        v_is_lo   = (v_lt_cnt <= CNTW'(M_LO)) && (CNTW'(M_LO) < v_le_cnt);
        v_is_hi   = (v_lt_cnt <= CNTW'(M_HI)) && (CNTW'(M_HI) < v_le_cnt);
        v_msum    = {1'b0, r_med_lo} + {1'b0, r_med_hi};
        // 2*res against trust*(lo+hi); for an odd window lo and hi coincide
        v_keep    = !({{(RHSW - RESW - 1){1'b0}}, r_res, 1'b0} > r_rhs);
        w_divisor = (r_cnt == '0) ? CNTW'(1) : r_cnt;
        v_div_wait = (r_state == S_DW1) || (r_state == S_DW2);
    end

    always_comb begin
        w_ctrl          = '0;
        w_ctrl.load     = w_accept;
        w_ctrl.rot_sk   = (r_state == S_SUM);
        w_ctrl.set_res  = (r_state == S_RES);
        w_ctrl.rot_res  = (r_state == S_MED);
        w_ctrl.set_keep = (r_state == S_CMP);
        w_ctrl.keep     = v_keep;
        w_ctrl.shift    = w_out_fire;
        w_div_start     = (r_state == S_DG1) || (r_state == S_DG2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_trust     <= TRUST_RESET;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_TRUST)) begin
                r_trust <= pwdata[3:0];
            end
            if (r_out_valid && i_smoothed_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x     <= i_sample;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_step  <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (w_head_keep) begin
                        r_acc <= r_acc + v_head_ext;
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                    r_step <= r_step + STEPW'(1);
                    if (v_last) begin
                        r_step  <= '0;
                        r_state <= S_DG1;
                    end
                end
                S_DG1: begin
                    r_state <= S_DW1;
                end
                S_DW1: begin
                    if (w_div_done) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    r_res   <= v_abs;
                    r_state <= S_MED;
                end
                S_MED: begin
                    if (v_is_lo) begin
                        r_med_lo <= w_res[0];
                    end
                    if (v_is_hi) begin
                        r_med_hi <= w_res[0];
                    end
                    r_step <= r_step + STEPW'(1);
                    if (v_last) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rhs   <= RHSW'(v_msum) * RHSW'(r_trust);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // excluded item leaves the kept sum and count
                    if (!v_keep) begin
                        r_acc <= r_acc - v_x_ext;
                        r_cnt <= r_cnt - CNTW'(1);
                    end
                    r_state <= S_DG2;
                end
                S_DG2: begin
                    r_state <= S_DW2;
                end
                S_DW2: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_fire) begin
                        r_out_valid <= 1'b1;
                        r_smoothed  <= v_avg;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rmaor_window #(
        .WINDOW       (WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_sample    (i_sample),
        .i_res       (v_abs),
        .o_head_smp  (w_head_smp),
        .o_head_keep (w_head_keep),
        .o_res       (w_res)
    );

    rmaor_div #(
        .NW (SUMW),
        .DW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_acc),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    `RMAOR_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, w_div_done, v_div_wait)
    `RMAOR_ASSERT_NEXT(a_accept_starts_sum, i_clk, i_rst_n, w_accept, r_state == S_SUM)
    `RMAOR_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_out_fire, o_smoothed_valid)
    `RMAOR_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, r_state != S_IDLE, r_cnt <= CNTW'(WINDOW))

endmodule

`default_nettype wire
